// ===== hdl/cts_pkg.sv =====
package cts_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_BYTE     = 2'd1,
    OP_RX_FRAME = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_FRAME    = 3'd0,
    ST_LAST     = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_REJECT   = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_TX_IDENTIFIER    = 1'b0,
    CFG_FC_TIMEOUT_TICKS = 1'b1
  } cfg_index_t;

  localparam int unsigned CfgDataWidth = 24;

  localparam logic [10:0] TxIdentifierReset   = 11'd2016;
  localparam logic [23:0] FcTimeoutTicksReset = 24'd2000000;

  typedef struct packed {
    op_t         operation;
    logic [11:0] message_length;
    logic [7:0]  data_byte;
    logic [7:0]  rx_first_byte;
    logic [7:0]  rx_second_byte;
    logic [7:0]  rx_third_byte;
  } item_t;

  typedef struct packed {
    logic [63:0] frame_bytes;
    logic [3:0]  frame_length;
    logic [10:0] frame_identifier;
    logic [6:0]  gap_ms;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic [10:0] tx_identifier;
    logic [23:0] fc_timeout_ticks;
  } cfg_t;

endpackage

// ===== hdl/cts_item_if.sv =====
interface cts_item_if import cts_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== hdl/cts_result_if.sv =====
interface cts_result_if import cts_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== hdl/cts_seg_core.sv =====
module cts_seg_core import cts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    has_result,
  output result_t result
);

  // Protocol control information and flow status nibbles, then frame size limits
  localparam logic [3:0] PciFirst   = 4'h1;
  localparam logic [3:0] PciConsec  = 4'h2;
  localparam logic [3:0] PciFlowCtl = 4'h3;
  localparam logic [3:0] FsClear    = 4'h0;
  localparam logic [3:0] FsWait     = 4'h1;
  localparam logic [3:0] FsOverflow = 4'h2;
  localparam logic [11:0] SingleMax = 12'd7;
  localparam logic [11:0] FirstData = 12'd6;
  localparam logic [2:0] LastSlot   = 3'd6;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_SINGLE  = 5'b00010,
    PH_FIRST   = 5'b00100,
    PH_WAIT_FC = 5'b01000,
    PH_CONSEC  = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [11:0] total_length, total_length_next;
  logic [11:0] bytes_taken, bytes_taken_next;
  logic [2:0]  cf_pos, cf_pos_next;
  logic [55:0] pending_frame, pending_frame_next;
  logic [3:0]  sequence_number, sequence_number_next;
  logic [7:0]  block_size_limit, block_size_limit_next;
  logic [7:0]  frames_in_block, frames_in_block_next;
  logic [7:0]  separation_ms, separation_ms_next;
  logic [23:0] wait_ticks, wait_ticks_next;

  logic [55:0] pend_work;
  logic [11:0] taken_inc;
  logic [7:0]  block_inc;
  logic [23:0] ticks_inc;
  logic        is_last;
  logic [7:0]  res_byte0;
  logic [3:0]  res_dlc;
  logic [6:0]  res_gap;
  status_t     res_status;

  // OR a data byte into frame byte position 1..7
  function automatic logic [55:0] place_byte(logic [55:0] frame, logic [2:0] slot,
                                             logic [7:0] value);
    logic [55:0] f;
    f = frame;
    for (int k = 0; k < 7; k++) begin
      if (slot == 3'(k + 1)) f[(6 - k) * 8 +: 8] = f[(6 - k) * 8 +: 8] | value;
    end
    return f;
  endfunction

  assign taken_inc = bytes_taken + 12'd1;
  assign block_inc = frames_in_block + 8'd1;
  assign ticks_inc = (wait_ticks != '1) ? wait_ticks + 24'd1 : wait_ticks;
  assign is_last   = taken_inc >= total_length;

  // Next state and result for the item in the stage
  always_comb begin
    phase_next            = phase;
    total_length_next     = total_length;
    bytes_taken_next      = bytes_taken;
    cf_pos_next           = cf_pos;
    pending_frame_next    = pending_frame;
    sequence_number_next  = sequence_number;
    block_size_limit_next = block_size_limit;
    frames_in_block_next  = frames_in_block;
    separation_ms_next    = separation_ms;
    wait_ticks_next       = wait_ticks;
    pend_work             = pending_frame;
    has_result            = 1'b0;
    res_byte0             = 8'd0;
    res_dlc               = 4'd0;
    res_gap               = 7'd0;
    res_status            = ST_FRAME;

    unique case (item.operation)
      OP_START: begin
        total_length_next     = item.message_length;
        bytes_taken_next      = 12'd0;
        cf_pos_next           = 3'd0;
        sequence_number_next  = 4'd1;
        frames_in_block_next  = 8'd0;
        block_size_limit_next = 8'd0;
        separation_ms_next    = 8'd0;
        wait_ticks_next       = 24'd0;
        pend_work             = 56'd0;
        if (item.message_length == 12'd0) begin
          // Empty message leaves as a bare single frame
          phase_next = PH_IDLE;
          has_result = 1'b1;
          res_dlc    = 4'd1;
          res_status = ST_LAST;
        end else if (item.message_length <= SingleMax) begin
          phase_next = PH_SINGLE;
        end else begin
          phase_next = PH_FIRST;
          pend_work  = place_byte(pend_work, 3'd1, item.message_length[7:0]);
        end
        pending_frame_next = pend_work;
      end

      OP_BYTE: begin
        unique case (phase)
          PH_SINGLE: begin
            pend_work        = place_byte(pend_work, bytes_taken[2:0] + 3'd1, item.data_byte);
            bytes_taken_next = taken_inc;
            if (is_last) begin
              has_result         = 1'b1;
              res_byte0          = {4'd0, total_length[3:0]};
              res_dlc            = total_length[3:0] + 4'd1;
              res_status         = ST_LAST;
              phase_next         = PH_IDLE;
              pending_frame_next = 56'd0;
            end else begin
              pending_frame_next = pend_work;
            end
          end
          PH_FIRST: begin
            pend_work        = place_byte(pend_work, bytes_taken[2:0] + 3'd2, item.data_byte);
            bytes_taken_next = taken_inc;
            if (taken_inc >= FirstData) begin
              has_result           = 1'b1;
              res_byte0            = {PciFirst, total_length[11:8]};
              res_dlc              = 4'd8;
              pending_frame_next   = 56'd0;
              phase_next           = PH_WAIT_FC;
              wait_ticks_next      = 24'd0;
              frames_in_block_next = 8'd0;
            end else begin
              pending_frame_next = pend_work;
            end
          end
          PH_CONSEC: begin
            pend_work        = place_byte(pend_work, cf_pos + 3'd1, item.data_byte);
            bytes_taken_next = taken_inc;
            if (is_last || cf_pos == LastSlot) begin
              has_result           = 1'b1;
              res_byte0            = {PciConsec, sequence_number};
              res_dlc              = {1'b0, cf_pos} + 4'd2;
              res_gap              = (separation_ms != 8'd0 && !separation_ms[7])
                                     ? separation_ms[6:0] : 7'd0;
              res_status           = is_last ? ST_LAST : ST_FRAME;
              sequence_number_next = sequence_number + 4'd1;
              pending_frame_next   = 56'd0;
              cf_pos_next          = 3'd0;
              if (is_last) begin
                phase_next = PH_IDLE;
              end else if (block_size_limit != 8'd0) begin
                // Block done: wait for the next flow control
                if (block_inc >= block_size_limit) begin
                  frames_in_block_next = 8'd0;
                  phase_next           = PH_WAIT_FC;
                  wait_ticks_next      = 24'd0;
                end else begin
                  frames_in_block_next = block_inc;
                end
              end
            end else begin
              cf_pos_next        = cf_pos + 3'd1;
              pending_frame_next = pend_work;
            end
          end
          default: begin
            // Byte out of turn: reject, keep state
            has_result = 1'b1;
            res_status = ST_REJECT;
          end
        endcase
      end

      OP_RX_FRAME: begin
        if (phase == PH_WAIT_FC && item.rx_first_byte[7:4] == PciFlowCtl) begin
          unique case (item.rx_first_byte[3:0])
            FsClear: begin
              block_size_limit_next = item.rx_second_byte;
              separation_ms_next    = item.rx_third_byte;
              frames_in_block_next  = 8'd0;
              phase_next            = PH_CONSEC;
            end
            FsWait: begin
              wait_ticks_next = 24'd0;
            end
            FsOverflow: begin
              phase_next         = PH_IDLE;
              pending_frame_next = 56'd0;
              has_result         = 1'b1;
              res_status         = ST_OVERFLOW;
            end
            default: ;
          endcase
        end
      end

      default: begin
        // Time tick: count only while awaiting flow control
        if (phase == PH_WAIT_FC) begin
          wait_ticks_next = ticks_inc;
          if (ticks_inc >= cfg.fc_timeout_ticks) begin
            phase_next         = PH_IDLE;
            pending_frame_next = 56'd0;
            has_result         = 1'b1;
            res_status         = ST_TIMEOUT;
          end
        end
      end
    endcase
  end

  // Assemble the result beat
  always_comb begin
    result.frame_bytes      = (res_dlc != 4'd0) ? {res_byte0, pend_work} : 64'd0;
    result.frame_length     = res_dlc;
    result.frame_identifier = (res_dlc != 4'd0) ? cfg.tx_identifier : 11'd0;
    result.gap_ms           = res_gap;
    result.status           = res_status;
  end

  // Advance the state on each item taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      total_length     <= 12'd0;
      bytes_taken      <= 12'd0;
      cf_pos           <= 3'd0;
      pending_frame    <= 56'd0;
      sequence_number  <= 4'd1;
      block_size_limit <= 8'd0;
      frames_in_block  <= 8'd0;
      separation_ms    <= 8'd0;
      wait_ticks       <= 24'd0;
    end else if (fire) begin
      phase            <= phase_next;
      total_length     <= total_length_next;
      bytes_taken      <= bytes_taken_next;
      cf_pos           <= cf_pos_next;
      pending_frame    <= pending_frame_next;
      sequence_number  <= sequence_number_next;
      block_size_limit <= block_size_limit_next;
      frames_in_block  <= frames_in_block_next;
      separation_ms    <= separation_ms_next;
      wait_ticks       <= wait_ticks_next;
    end
  end

endmodule

// ===== hdl/cts_result_reg.sv =====
module cts_result_reg import cts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    load_valid,
  input  result_t load_data,
  output logic    free,
  cts_result_if.source result
);

  logic    out_valid;
  result_t out_data;

  // Slot is free when empty or being drained this cycle
  assign free = !out_valid || result.ready;

  // Hold the beat until taken; load replaces it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_data <= load_data;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_data;

endmodule

// ===== hdl/can_transport_segmenting_sender.sv =====
// Segmenting CAN transport sender. Takes one item per clock cycle, sustained:
// a new item is accepted every cycle unless the input register is full and the
// result register holds a beat that the sink is not taking in that cycle. Each
// item passes the input register and the segmentation logic into the result
// register, where its beat waits until taken; items that cause no result
// (start of a non-empty message, most payload bytes, flow-control frames other
// than overflow, ticks before the timeout) produce no beat. Configuration
// writes (identifier, flow-control timeout) take effect at once and are meant
// for idle periods only. No memory, no clearing pass after reset.
module can_transport_segmenting_sender import cts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  cfg_index_t              cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  cts_item_if.sink                item,
  cts_result_if.source            result
);

  cfg_t    cfg;
  logic    stage_valid;
  item_t   stage_item;
  logic    advance;
  logic    fire;
  logic    has_result;
  result_t core_result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tx_identifier    <= TxIdentifierReset;
      cfg.fc_timeout_ticks <= FcTimeoutTicksReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TX_IDENTIFIER:    cfg.tx_identifier    <= cfg_data[10:0];
        CFG_FC_TIMEOUT_TICKS: cfg.fc_timeout_ticks <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Input register: refill whenever the stage empties
  assign fire       = stage_valid && advance;
  assign item.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_item <= item.payload;
    end
  end

  cts_seg_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (stage_item),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (core_result)
  );

  cts_result_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .load_valid (has_result),
    .load_data  (core_result),
    .free       (advance),
    .result     (result)
  );

  // A processed item with a result shows up as a beat next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    fire && has_result |=> result.valid)
    else $error("result beat lost");

  // An empty result register never blocks input
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> item.ready)
    else $error("input stalled with free result register");

  // Aborts and rejects carry no frame
  a_no_frame_on_abort: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.payload.status == ST_OVERFLOW ||
                     result.payload.status == ST_TIMEOUT ||
                     result.payload.status == ST_REJECT)
    |-> result.payload.frame_length == 4'd0 && result.payload.frame_bytes == 64'd0)
    else $error("frame data on abort or reject");

endmodule
